FILE: src/tfd_pkg.sv
// ----------------------------------------------------------------------------
// Texel format decoder package
// Format codes, the decoded pixel type and channel widening helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfd_pkg;

  localparam int TexelWidth   = 32;
  localparam int ChannelWidth = 8;
  localparam int FormatWidth  = 4;
  localparam int AddrWidth    = 3;
  localparam int DataWidth    = 32;

  localparam logic [FormatWidth-1:0] FMT_RGBA8  = 4'd0;
  localparam logic [FormatWidth-1:0] FMT_RGB8   = 4'd1;
  localparam logic [FormatWidth-1:0] FMT_RGB5A1 = 4'd2;
  localparam logic [FormatWidth-1:0] FMT_RGB565 = 4'd3;
  localparam logic [FormatWidth-1:0] FMT_RGBA4  = 4'd4;
  localparam logic [FormatWidth-1:0] FMT_IA8    = 4'd5;
  localparam logic [FormatWidth-1:0] FMT_I8     = 4'd6;
  localparam logic [FormatWidth-1:0] FMT_A8     = 4'd7;
  localparam logic [FormatWidth-1:0] FMT_IA4    = 4'd8;

  localparam logic [0:0] REG_TEXEL_FORMAT = 1'b0;

  localparam logic [ChannelWidth-1:0] CHAN_MAX  = 8'hFF;
  localparam logic [ChannelWidth-1:0] CHAN_ZERO = 8'h00;

  typedef struct packed {
    logic [ChannelWidth-1:0] red;
    logic [ChannelWidth-1:0] green;
    logic [ChannelWidth-1:0] blue;
    logic [ChannelWidth-1:0] alpha;
    logic                    format_error;
  } pixel_t;

  function automatic logic [ChannelWidth-1:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

  function automatic logic [ChannelWidth-1:0] widen6(input logic [5:0] v);
    widen6 = {v, v[5:4]};
  endfunction

  function automatic logic [ChannelWidth-1:0] widen4(input logic [3:0] v);
    widen4 = {v, v};
  endfunction

  function automatic logic [ChannelWidth-1:0] widen1(input logic v);
    widen1 = v ? CHAN_MAX : CHAN_ZERO;
  endfunction

endpackage

`default_nettype wire

FILE: src/tfd_regs.sv
// ----------------------------------------------------------------------------
// Texel format decoder configuration registers
// APB-style register port holding the texel format code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfd_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tfd_pkg::AddrWidth-1:0]   paddr,
  input  wire logic [tfd_pkg::DataWidth-1:0]   pwdata,
  output logic      [tfd_pkg::DataWidth-1:0]   prdata,
  output logic                              pready,
  output logic      [tfd_pkg::FormatWidth-1:0] texel_format
);
  import tfd_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_TEXEL_FORMAT);

  always_ff @(posedge clk) begin
    if (rst) begin
      texel_format <= FMT_RGBA8;
    end else if (wr_en) begin
      texel_format <= pwdata[FormatWidth-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TEXEL_FORMAT) begin
      prdata[FormatWidth-1:0] = texel_format;
    end
  end

endmodule

`default_nettype wire

FILE: src/tfd_decode.sv
// ----------------------------------------------------------------------------
// Texel format decoder datapath
// Selects and widens the channel fields of one raw texel for the given format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfd_decode (
  input  wire logic [tfd_pkg::TexelWidth-1:0]  texel,
  input  wire logic [tfd_pkg::FormatWidth-1:0] format,
  output tfd_pkg::pixel_t                       pixel
);
  import tfd_pkg::*;

  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [7:0]  b3;
  logic [15:0] h;
  logic [7:0]  ia4_i;

  assign b0    = texel[7:0];
  assign b1    = texel[15:8];
  assign b2    = texel[23:16];
  assign b3    = texel[31:24];
  assign h     = texel[15:0];
  assign ia4_i = {b0[7:4], 4'h0};

  always_comb begin
    pixel = '0;
    unique case (format)
      FMT_RGBA8: begin
        pixel.red = b3; pixel.green = b2; pixel.blue = b1; pixel.alpha = b0;
      end
      FMT_RGB8: begin
        pixel.red = b2; pixel.green = b1; pixel.blue = b0; pixel.alpha = CHAN_MAX;
      end
      FMT_RGB5A1: begin
        pixel.red   = widen5(h[15:11]);
        pixel.green = widen5(h[10:6]);
        pixel.blue  = widen5(h[5:1]);
        pixel.alpha = widen1(h[0]);
      end
      FMT_RGB565: begin
        pixel.red   = widen5(h[15:11]);
        pixel.green = widen6(h[10:5]);
        pixel.blue  = widen5(h[4:0]);
        pixel.alpha = CHAN_MAX;
      end
      FMT_RGBA4: begin
        pixel.red   = widen4(h[15:12]);
        pixel.green = widen4(h[11:8]);
        pixel.blue  = widen4(h[7:4]);
        pixel.alpha = widen4(h[3:0]);
      end
      FMT_IA8: begin
        pixel.red = b0; pixel.green = b0; pixel.blue = b0; pixel.alpha = b1;
      end
      FMT_I8: begin
        pixel.red = b0; pixel.green = b0; pixel.blue = b0; pixel.alpha = CHAN_MAX;
      end
      FMT_A8: begin
        pixel.alpha = b0;
      end
      FMT_IA4: begin
        pixel.red   = ia4_i;
        pixel.green = ia4_i;
        pixel.blue  = ia4_i;
        pixel.alpha = {b0[3:0], 4'h0};
      end
      default: begin
        pixel.format_error = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/texel_format_decoder_unit.sv
// ----------------------------------------------------------------------------
// Texel format decoder unit
// Decodes one raw texel per word into 8-bit red, green, blue and alpha.
// ----------------------------------------------------------------------------
// The unit accepts one texel word every cycle while in_stall is low and
// returns its decoded pixel through one input register and one output
// register, with the decode logic between them. Throughput is one word per
// cycle as long as the output side is not stalled; out_stall reaches
// in_stall only when both registers hold words. The texel format is set
// through the register port and must be written while no words are in
// flight. An unknown format code returns zero channels with format_error set.
`timescale 1ns / 1ps
`default_nettype none

module texel_format_decoder_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tfd_pkg::AddrWidth-1:0]      paddr,
  input  wire logic [tfd_pkg::DataWidth-1:0]      pwdata,
  output logic      [tfd_pkg::DataWidth-1:0]      prdata,
  output logic                                    pready,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [tfd_pkg::TexelWidth-1:0]     texel_bytes,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [tfd_pkg::ChannelWidth-1:0]   red,
  output logic      [tfd_pkg::ChannelWidth-1:0]   green,
  output logic      [tfd_pkg::ChannelWidth-1:0]   blue,
  output logic      [tfd_pkg::ChannelWidth-1:0]   alpha,
  output logic                                    format_error
);
  import tfd_pkg::*;

  logic [FormatWidth-1:0] texel_format;
  logic                   stage_valid;
  logic [TexelWidth-1:0]  stage_texel;
  logic                   out_free;
  pixel_t                 pixel;

  tfd_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .texel_format (texel_format)
  );

  tfd_decode u_decode (
    .texel  (stage_texel),
    .format (texel_format),
    .pixel  (pixel)
  );

  assign out_free = !(out_valid && out_stall);
  assign in_stall = stage_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_texel <= texel_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && out_free) begin
      red          <= pixel.red;
      green        <= pixel.green;
      blue         <= pixel.blue;
      alpha        <= pixel.alpha;
      format_error <= pixel.format_error;
    end
  end

endmodule

`default_nettype wire

FILE: src/tfd_checker.sv
// ----------------------------------------------------------------------------
// Texel format decoder checker
// Port-level assertions for the decoder unit, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] red,
  input wire logic [7:0] green,
  input wire logic [7:0] blue,
  input wire logic [7:0] alpha,
  input wire logic       format_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output word");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && format_error |-> red == 8'd0 && green == 8'd0 && blue == 8'd0
      && alpha == 8'd0)
    else $error("nonzero channels on format error");

endmodule

bind texel_format_decoder_unit tfd_checker u_tfd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .red          (red),
  .green        (green),
  .blue         (blue),
  .alpha        (alpha),
  .format_error (format_error)
);

`default_nettype wire

FILE: verif/texel_format_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// Texel format decoder unit test
// Sets the texel format through the register port and streams texel words
// through the unit. Each accepted word is decoded by a local model and
// queued. Each decoded pixel that leaves the unit is compared field by
// field with the oldest queued one. Both sides of the stream idle at
// random, and the output side also holds off for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module texel_format_decoder_unit_test;

  import tfd_pkg::*;

  localparam logic [FormatWidth-1:0] FMT_CODE_MAX = 4'd15;
  localparam logic [AddrWidth-1:0] ADDR_TEXEL_FORMAT = AddrWidth'(4 * REG_TEXEL_FORMAT);
  localparam int OUT_HOLD_CYCLES = 200;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TexelWidth-1:0] texel_bytes = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ChannelWidth-1:0] red;
  logic [ChannelWidth-1:0] green;
  logic [ChannelWidth-1:0] blue;
  logic [ChannelWidth-1:0] alpha;
  logic format_error;

  pixel_t expected_pixels[$];
  logic [FormatWidth-1:0] current_format = FMT_RGBA8;
  int mismatches = 0;
  bit in_idling_on = 1'b1;
  bit out_idling_on = 1'b1;
  int out_hold_request = 0;
  int out_stall_left = 0;

  texel_format_decoder_unit uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .texel_bytes(texel_bytes),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red(red),
    .green(green),
    .blue(blue),
    .alpha(alpha),
    .format_error(format_error)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic pixel_t decode_texel(input logic [FormatWidth-1:0] fmt,
                                          input logic [TexelWidth-1:0] raw);
    pixel_t px;
    logic [15:0] h;
    logic [7:0] b0;
    px = '0;
    h = raw[15:0];
    b0 = raw[7:0];
    case (fmt)
      FMT_RGBA8: begin
        px.red = raw[31:24];
        px.green = raw[23:16];
        px.blue = raw[15:8];
        px.alpha = raw[7:0];
      end
      FMT_RGB8: begin
        px.red = raw[23:16];
        px.green = raw[15:8];
        px.blue = raw[7:0];
        px.alpha = CHAN_MAX;
      end
      FMT_RGB5A1: begin
        px.red = {h[15:11], h[15:13]};
        px.green = {h[10:6], h[10:8]};
        px.blue = {h[5:1], h[5:3]};
        px.alpha = {8{h[0]}};
      end
      FMT_RGB565: begin
        px.red = {h[15:11], h[15:13]};
        px.green = {h[10:5], h[10:9]};
        px.blue = {h[4:0], h[4:2]};
        px.alpha = CHAN_MAX;
      end
      FMT_RGBA4: begin
        px.red = {2{h[15:12]}};
        px.green = {2{h[11:8]}};
        px.blue = {2{h[7:4]}};
        px.alpha = {2{h[3:0]}};
      end
      FMT_IA8: begin
        px.red = b0;
        px.green = b0;
        px.blue = b0;
        px.alpha = raw[15:8];
      end
      FMT_I8: begin
        px.red = b0;
        px.green = b0;
        px.blue = b0;
        px.alpha = CHAN_MAX;
      end
      FMT_A8: begin
        px.alpha = b0;
      end
      FMT_IA4: begin
        px.red = {b0[7:4], 4'b0000};
        px.green = {b0[7:4], 4'b0000};
        px.blue = {b0[7:4], 4'b0000};
        px.alpha = {b0[3:0], 4'b0000};
      end
      default: begin
        px.format_error = 1'b1;
      end
    endcase
    return px;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [TexelWidth-1:0] pick_texel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return TexelWidth'(1) << $urandom_range(0, TexelWidth - 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("Mismatch on %s: expected %02h, got %02h at %0t", what, want, got, $realtime);
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected pixel word at %0t", $realtime);
        end
      end else begin
        want = expected_pixels.pop_front();
        if (red !== want.red) note_mismatch("red", want.red, red);
        if (green !== want.green) note_mismatch("green", want.green, green);
        if (blue !== want.blue) note_mismatch("blue", want.blue, blue);
        if (alpha !== want.alpha) note_mismatch("alpha", want.alpha, alpha);
        if (format_error !== want.format_error) begin
          note_mismatch("format_error", 8'(want.format_error), 8'(format_error));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (out_hold_request > 0) begin
      out_stall_left = out_hold_request;
      out_hold_request = 0;
    end
    if (out_stall_left > 0) begin
      out_stall <= 1'b1;
      out_stall_left--;
    end else if (out_idling_on && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      out_stall_left = pick_gap() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_texel(input logic [TexelWidth-1:0] raw);
    int gap;
    gap = (in_idling_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      texel_bytes <= $urandom;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    texel_bytes <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pixels.push_back(decode_texel(current_format, raw));
  endtask

  task automatic write_format(input logic [FormatWidth-1:0] fmt);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_TEXEL_FORMAT;
    pwdata <= {28'($urandom_range(0, (1 << 28) - 1)), fmt};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    current_format = fmt;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[FormatWidth-1:0] !== fmt) begin
      note_mismatch("texel_format readback", 8'(fmt), 8'(prdata[FormatWidth-1:0]));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_format();
    send_texel(32'h0102_0304);
    send_texel(32'hA5C3_3C5A);
  endtask

  task automatic test_every_format();
    logic [FormatWidth-1:0] codes[$];
    codes = '{FMT_RGBA8, FMT_RGB8, FMT_RGB5A1, FMT_RGB565, FMT_RGBA4, FMT_IA8,
              FMT_I8, FMT_A8, FMT_IA4, FMT_IA4 + 4'd1, FMT_CODE_MAX};
    foreach (codes[i]) begin
      write_format(codes[i]);
      send_texel('0);
      send_texel('1);
    end
  endtask

  task automatic test_output_backpressure();
    write_format(FMT_RGB565);
    in_idling_on = 1'b0;
    out_hold_request = OUT_HOLD_CYCLES;
    repeat (40) send_texel(pick_texel());
    in_idling_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [FormatWidth-1:0] fmt;
    int count;
    for (int phase = 0; phase < 22; phase++) begin
      if (phase <= FMT_CODE_MAX) begin
        fmt = FormatWidth'(phase);
      end else if ($urandom_range(0, 4) == 0) begin
        fmt = FormatWidth'($urandom_range(FMT_IA4 + 1, FMT_CODE_MAX));
      end else begin
        fmt = FormatWidth'($urandom_range(FMT_RGBA8, FMT_IA4));
      end
      write_format(fmt);
      in_idling_on = ($urandom_range(0, 3) != 0);
      out_idling_on = ($urandom_range(0, 3) != 0);
      count = $urandom_range(50, 80);
      repeat (count) send_texel(pick_texel());
    end
    in_idling_on = 1'b1;
    out_idling_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_format();
    test_every_format();
    test_output_backpressure();
    test_random_traffic();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
src/tfd_pkg.sv
src/tfd_regs.sv
src/tfd_decode.sv
src/texel_format_decoder_unit.sv
src/tfd_checker.sv
verif/texel_format_decoder_unit_test.sv
